// ----- design/rsa_pkg.sv -----
// Package for the record slot allocator: constants, codes and word types.
// No dependencies.
package rsa_pkg;

  localparam int Slots = 256;
  localparam int IdxW  = $clog2(Slots);
  localparam int CntW  = $clog2(Slots + 1);

  localparam logic [1:0] MarkEmpty = 2'd0;
  localparam logic [1:0] MarkLive  = 2'd1;
  localparam logic [1:0] MarkTomb  = 2'd2;

  localparam logic [2:0] OpAppend  = 3'd0;
  localparam logic [2:0] OpDelete  = 3'd1;
  localparam logic [2:0] OpNext    = 3'd2;
  localparam logic [2:0] OpCompact = 3'd3;
  localparam logic [2:0] OpClear   = 3'd4;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StRange   = 3'd1;
  localparam logic [2:0] StDeleted = 3'd2;
  localparam logic [2:0] StFull    = 3'd3;
  localparam logic [2:0] StError   = 3'd4;

  localparam logic [1:0] RegCapacity = 2'd0;
  localparam logic [1:0] RegRing     = 2'd1;
  localparam logic [1:0] RegFreeList = 2'd2;

  typedef struct packed {
    logic [2:0] operation;
    logic [8:0] record_number;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [8:0] record_out;
    logic [8:0] live_total;
  } out_word_t;

endpackage

// ----- design/rsa_ram.sv -----
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module rsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- design/record_slot_allocator_unit.sv -----
// Record slot allocator top level: slot mark and link tables in RAM, sequencer.
// Depends on rsa_pkg and rsa_ram.
//
// Usage: an input word (operation, record_number) is taken on in_valid_i &&
// in_ready_o; one result word (status, record_out, live_total) follows on the
// output channel. One word is handled at a time; a result waiting in the output
// register does not stop the next word from being taken.
// After a word is taken: clear, errors, range misses and next-live answered
// without a walk go straight to the done state; a fresh-slot or ring append
// passes through the push state; a delete reads and then checks its slot; an
// append from the free list reads and checks the head slot, then pushes.
// Ring-full next-live subtracts capacity from record_number step by step. The
// scans for append, next-live and compact walk the mark RAM slot by slot
// (registered read, then check), up to used_slots slots.
// Configuration goes through the APB port at byte addresses 0, 4, 8 and must be
// written only while idle; the block itself does not enforce this. Reset clears
// counters, the free list head and the ring pointer; the tables need no clearing
// (slots past used_slots are never read). When the receiver stalls, the result
// holds and the next word waits its turn once its own result is ready.
module record_slot_allocator_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rsa_pkg::in_word_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rsa_pkg::out_word_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import rsa_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RD    = 8'b0000_0010,
    S_EVAL  = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_SCANW = 8'b0001_0000,
    S_DONE  = 8'b0010_0000,
    S_CMPW  = 8'b0100_0000,
    S_PUSH  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [8:0] cap_q;
  logic       ring_q, fl_q;
  logic [1:0] reg_idx;
  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= 9'd256;
      ring_q <= 1'b0;
      fl_q   <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        RegCapacity: cap_q  <= pwdata[8:0];
        RegRing:     ring_q <= pwdata[0];
        RegFreeList: fl_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      RegCapacity: prdata = {23'd0, cap_q};
      RegRing:     prdata = {31'd0, ring_q};
      RegFreeList: prdata = {31'd0, fl_q};
      default:     prdata = '0;
    endcase
  end

  logic [CntW-1:0] cap;
  assign cap = (cap_q < 9'(Slots)) ? CntW'(cap_q) : CntW'(Slots);

  // State registers
  logic [CntW-1:0] used_q, used_d, live_q, live_d, top_q, top_d;
  logic [IdxW-1:0] old_q, old_d;
  logic [2:0]      op_q, op_d;
  logic [8:0]      rn_q, rn_d;
  logic [CntW-1:0] ptr_q, ptr_d;     // scan index / target slot / ring remainder
  logic [CntW-1:0] acc_q, acc_d;     // compact live count
  logic [CntW-1:0] head_q, head_d;   // compact free list head
  logic            ovalid_q, ovalid_d;
  out_word_t       odata_q, odata_d;
  out_word_t       wrk_q, wrk_d;     // result under construction

  // RAM ports
  logic            mwe, lwe;
  logic [IdxW-1:0] maddr;
  logic [1:0]      mwdata, mrdata;
  logic [CntW-1:0] lwdata, lrdata;

  rsa_ram #(.Width(2), .Depth(Slots)) u_mark (
    .clk_i, .we_i(mwe), .addr_i(maddr), .wdata_i(mwdata), .rdata_o(mrdata));
  rsa_ram #(.Width(CntW), .Depth(Slots)) u_link (
    .clk_i, .we_i(lwe), .addr_i(maddr), .wdata_i(lwdata), .rdata_o(lrdata));

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  logic            full;
  logic [IdxW-1:0] oldc;
  assign full = live_q >= cap;
  assign oldc = (CntW'(old_q) < cap) ? old_q : '0;

  always_comb begin
    state_d = state_q; used_d = used_q; live_d = live_q; top_d = top_q;
    old_d = old_q; op_d = op_q; rn_d = rn_q; ptr_d = ptr_q; acc_d = acc_q;
    head_d = head_q; ovalid_d = ovalid_q; odata_d = odata_q; wrk_d = wrk_q;
    mwe = 1'b0; lwe = 1'b0; maddr = ptr_q[IdxW-1:0];
    mwdata = MarkLive; lwdata = top_q;

    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;

    case (state_q)
      // Take a word and decide the first access
      S_IDLE: if (in_valid_i && in_ready_o) begin
        op_d = in_data_i.operation;
        rn_d = in_data_i.record_number;
        wrk_d = '{status: StOk, record_out: 9'd0, live_total: live_q};
        state_d = S_DONE;
        case (in_data_i.operation)
          OpAppend: begin
            if (ring_q) begin
              if (cap == '0) wrk_d.status = StError;
              else if (!full) begin
                if (used_q >= cap) wrk_d.status = StFull;
                else begin
                  ptr_d = used_q; used_d = used_q + 1'b1;
                  live_d = (live_q < CntW'(Slots)) ? live_q + 1'b1 : live_q;
                  state_d = S_PUSH;
                end
              end else begin
                ptr_d = CntW'(oldc);
                old_d = (CntW'(oldc) + 1'b1 >= cap) ? '0 : IdxW'(oldc + 1'b1);
                state_d = S_PUSH;
              end
            end else if (fl_q && top_q != CntW'(Slots)) begin
              ptr_d = top_q; state_d = S_RD;
            end else begin
              if (used_q < cap) begin
                ptr_d = used_q; used_d = used_q + 1'b1;
                live_d = (live_q < CntW'(Slots)) ? live_q + 1'b1 : live_q;
                state_d = S_PUSH;
              end else begin
                ptr_d = '0; state_d = S_SCAN;
              end
            end
          end
          OpDelete: begin
            if (ring_q) wrk_d.status = StError;
            else if (in_data_i.record_number == 9'd0 ||
                     CntW'(in_data_i.record_number) > used_q)
              wrk_d.status = StRange;
            else begin
              ptr_d = CntW'(in_data_i.record_number) - 1'b1; state_d = S_RD;
            end
          end
          OpNext: begin
            if (ring_q && full && (in_data_i.record_number == 9'd0 ||
                CntW'(in_data_i.record_number) <= used_q)) begin
              ptr_d = CntW'(in_data_i.record_number);
              state_d = S_EVAL;
            end else if (ring_q && CntW'(in_data_i.record_number) > used_q) begin
              wrk_d.record_out = 9'd0;
            end else if (in_data_i.record_number == 9'd0 ||
                         CntW'(in_data_i.record_number) < used_q) begin
              ptr_d = CntW'(in_data_i.record_number); state_d = S_SCAN;
            end
          end
          OpCompact: begin
            if (ring_q) wrk_d.status = StError;
            else begin
              ptr_d = '0; acc_d = '0; head_d = CntW'(Slots); state_d = S_SCAN;
            end
          end
          OpClear: begin
            used_d = '0; live_d = '0; top_d = CntW'(Slots); old_d = '0;
            wrk_d.live_total = '0;
          end
          default: wrk_d.status = StError;
        endcase
      end
      // Ring-full next live: reduce the record number by capacity, one step a cycle
      S_EVAL: begin
        state_d = S_DONE;
        if (cap == '0) wrk_d.record_out = 9'd0;
        else if (rn_q == 9'd0) wrk_d.record_out = 9'(oldc) + 9'd1;
        else if (ptr_q >= cap) begin
          ptr_d = ptr_q - cap;
          state_d = S_EVAL;
        end
        else if (ptr_q == CntW'(oldc)) wrk_d.record_out = 9'd0;
        else wrk_d.record_out = 9'(ptr_q + 1'b1);
      end
      // Issue read of the target slot
      S_RD: state_d = S_CMPW;
      // Check mark/link of the target slot
      S_CMPW: begin
        if (op_q == OpAppend) begin
          if (ptr_q < used_q && mrdata == MarkTomb) begin
            top_d = (lrdata == CntW'(Slots) || lrdata < used_q) ? lrdata : CntW'(Slots);
            live_d = (live_q < CntW'(Slots)) ? live_q + 1'b1 : live_q;
            state_d = S_PUSH;
          end else begin
            top_d = CntW'(Slots);
            if (used_q < cap) begin
              ptr_d = used_q; used_d = used_q + 1'b1;
              live_d = (live_q < CntW'(Slots)) ? live_q + 1'b1 : live_q;
              state_d = S_PUSH;
            end else begin
              ptr_d = '0; state_d = S_SCAN;
            end
          end
        end else begin
          // delete
          if (mrdata == MarkTomb) wrk_d.status = StDeleted;
          else if (mrdata != MarkLive) wrk_d.status = StRange;
          else begin
            mwe = 1'b1; mwdata = MarkTomb;
            if (fl_q) begin
              lwe = 1'b1; lwdata = top_q; top_d = ptr_q;
            end
            live_d = (live_q > '0) ? live_q - 1'b1 : live_q;
          end
          state_d = S_DONE;
        end
      end
      // Write live mark into the chosen slot and answer
      S_PUSH: begin
        mwe = 1'b1; mwdata = MarkLive;
        wrk_d.record_out = 9'(ptr_q + 1'b1);
        state_d = S_DONE;
      end
      // Walk the mark table: issue read of ptr_q
      S_SCAN: begin
        if (ptr_q >= used_q) begin
          if (op_q == OpAppend) wrk_d.status = StFull;
          else if (op_q == OpCompact) begin
            live_d = acc_q; top_d = fl_q ? head_q : CntW'(Slots);
          end
          state_d = S_DONE;
        end else state_d = S_SCANW;
      end
      S_SCANW: begin
        state_d = S_SCAN;
        ptr_d = ptr_q + 1'b1;
        case (op_q)
          OpAppend: if (mrdata == MarkTomb) begin
            ptr_d = ptr_q;
            live_d = (live_q < CntW'(Slots)) ? live_q + 1'b1 : live_q;
            state_d = S_PUSH;
          end
          OpNext: if (mrdata == MarkLive) begin
            wrk_d.record_out = 9'(ptr_q + 1'b1);
            state_d = S_DONE;
          end
          default: begin
            if (mrdata == MarkLive) acc_d = acc_q + 1'b1;
            else if (mrdata == MarkTomb && fl_q) begin
              lwe = 1'b1; lwdata = head_q; head_d = ptr_q;
            end
          end
        endcase
      end
      // Move the result into the output register once it is free
      S_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          odata_d = wrk_q;
          if (wrk_q.status != StOk) odata_d.record_out = 9'd0;
          odata_d.live_total = 9'(live_q);
          ovalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; used_q <= '0; live_q <= '0; top_q <= CntW'(Slots);
      old_q <= '0; ovalid_q <= 1'b0; op_q <= '0; rn_q <= '0; ptr_q <= '0;
      acc_q <= '0; head_q <= '0;
    end else begin
      state_q <= state_d; used_q <= used_d; live_q <= live_d; top_q <= top_d;
      old_q <= old_d; ovalid_q <= ovalid_d; op_q <= op_d; rn_q <= rn_d;
      ptr_q <= ptr_d; acc_q <= acc_d; head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
    wrk_q <= wrk_d;
  end
endmodule

// ----- verif/tb.sv -----
// Testbench for record_slot_allocator_unit: directed and random words checked
// against a behavioral predictor of the slot table. Depends on rsa_pkg and the unit.
`timescale 1ns / 1ps

module tb;
  import rsa_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int DrainCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_word_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_word_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  record_slot_allocator_unit uut (.*);

  always #10 clk_i = ~clk_i;

  // Predicted table state and register copies
  logic [1:0] tbl_mark[Slots];
  logic [8:0] tbl_link[Slots];
  int used_n, live_n, flist_top, ring_old;
  int cap_reg, ring_reg, flist_reg;

  out_word_t result_q[$];
  int fail_cnt = 0;
  int snd_idle = 0, rcv_idle = 0;
  longint cyc = 0;

  // Timeout watchdog
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver stalls
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rcv_idle);
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data_o);
        fail_cnt++;
      end else begin
        exp_w = result_q.pop_front();
        if (exp_w.status !== out_data_o.status) begin
          $display("%0t: status exp %0d got %0d", $time, exp_w.status, out_data_o.status);
          fail_cnt++;
        end
        if (exp_w.record_out !== out_data_o.record_out) begin
          $display("%0t: record_out exp %0d got %0d", $time, exp_w.record_out,
                   out_data_o.record_out);
          fail_cnt++;
        end
        if (exp_w.live_total !== out_data_o.live_total) begin
          $display("%0t: live_total exp %0d got %0d", $time, exp_w.live_total,
                   out_data_o.live_total);
          fail_cnt++;
        end
      end
    end
  end

  function automatic int usable_slots();
    return cap_reg < Slots ? cap_reg : Slots;
  endfunction

  function automatic int find_live(int from);
    for (int i = from; i < used_n; i++)
      if (tbl_mark[i] == MarkLive) return i + 1;
    return 0;
  endfunction

  // Slot index for a normal append, or Slots when nothing is free
  function automatic int grab_slot();
    int h, nx;
    if (flist_reg != 0 && flist_top != Slots) begin
      h = flist_top;
      if (h < used_n && tbl_mark[h] == MarkTomb) begin
        nx = tbl_link[h];
        flist_top = (nx == Slots || nx < used_n) ? nx : Slots;
        return h;
      end
      flist_top = Slots;
    end
    if (used_n < usable_slots()) begin
      used_n++;
      return used_n - 1;
    end
    for (int i = 0; i < used_n; i++)
      if (tbl_mark[i] == MarkTomb) return i;
    return Slots;
  endfunction

  function automatic out_word_t apply_word(in_word_t w);
    out_word_t r;
    int cap, idx, rn, head, cnt, nx, old;
    logic full;
    cap = usable_slots();
    rn = w.record_number;
    r.status = StOk;
    r.record_out = '0;
    case (w.operation)
      OpAppend: begin
        idx = -1;
        if (ring_reg != 0) begin
          if (cap == 0) r.status = StError;
          else if (live_n < cap) begin
            if (used_n >= cap) r.status = StFull;
            else begin
              idx = used_n;
              used_n++;
              if (live_n < Slots) live_n++;
            end
          end else begin
            idx = ring_old < cap ? ring_old : 0;
            ring_old = (idx + 1) % cap;
          end
        end else begin
          idx = grab_slot();
          if (idx == Slots) begin
            r.status = StFull;
            idx = -1;
          end else if (live_n < Slots) live_n++;
        end
        if (idx >= 0) begin
          tbl_mark[idx] = MarkLive;
          r.record_out = 9'(idx + 1);
        end
      end
      OpDelete: begin
        if (ring_reg != 0) r.status = StError;
        else if (rn < 1 || rn > used_n) r.status = StRange;
        else if (tbl_mark[rn-1] == MarkTomb) r.status = StDeleted;
        else if (tbl_mark[rn-1] != MarkLive) r.status = StRange;
        else begin
          if (flist_reg != 0) begin
            tbl_link[rn-1] = 9'(flist_top);
            flist_top = rn - 1;
          end
          tbl_mark[rn-1] = MarkTomb;
          if (live_n > 0) live_n--;
        end
      end
      OpNext: begin
        full = live_n >= cap;
        old = ring_old < cap ? ring_old : 0;
        if (ring_reg == 0) r.record_out = 9'(find_live(rn));
        else if (rn == 0) begin
          if (!full) r.record_out = 9'(find_live(0));
          else if (cap != 0) r.record_out = 9'(old + 1);
        end else if (rn <= used_n) begin
          if (!full) r.record_out = 9'(find_live(rn));
          else if (cap != 0) begin
            nx = rn % cap;
            if (nx != old) r.record_out = 9'(nx + 1);
          end
        end
      end
      OpCompact: begin
        if (ring_reg != 0) r.status = StError;
        else begin
          cnt = 0;
          head = Slots;
          for (int i = 0; i < used_n; i++) begin
            if (tbl_mark[i] == MarkLive) cnt++;
            else if (tbl_mark[i] == MarkTomb && flist_reg != 0) begin
              tbl_link[i] = 9'(head);
              head = i;
            end
          end
          live_n = cnt;
          flist_top = flist_reg != 0 ? head : Slots;
        end
      end
      OpClear: begin
        used_n = 0;
        live_n = 0;
        flist_top = Slots;
        ring_old = 0;
      end
      default: r.status = StError;
    endcase
    if (r.status != StOk) r.record_out = '0;
    r.live_total = 9'(live_n);
    return r;
  endfunction

  // Send one word; called at a rising edge, returns at its acceptance edge
  task automatic send_word(logic [2:0] op, logic [8:0] rn);
    in_word_t w;
    w.operation = op;
    w.record_number = rn;
    if ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < snd_idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    result_q.push_back(apply_word(w));
  endtask

  // Let the block go idle before touching registers
  task automatic drain();
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, int val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegCapacity: cap_reg = val & 9'h1FF;
      RegRing:     ring_reg = val & 1;
      default:     flist_reg = val & 1;
    endcase
  endtask

  task automatic set_mode(int cap, int ring, int fl);
    drain();
    reg_write(RegCapacity, cap);
    reg_write(RegRing, ring);
    reg_write(RegFreeList, fl);
  endtask

  // Free-list reuse, deletes of every kind, compact, bad opcodes
  task automatic test_directed();
    set_mode(4, 0, 1);
    send_word(OpNext, 9'd0);
    for (int i = 0; i < 4; i++) send_word(OpAppend, 9'd0);
    send_word(OpAppend, 9'd0);
    send_word(OpDelete, 9'd2);
    send_word(OpDelete, 9'd2);
    send_word(OpDelete, 9'd0);
    send_word(OpDelete, 9'd5);
    send_word(OpDelete, 9'h1FF);
    send_word(OpDelete, 9'd4);
    send_word(OpNext, 9'd1);
    send_word(OpNext, 9'd256);
    send_word(OpAppend, 9'd0);
    send_word(OpCompact, 9'd0);
    send_word(OpAppend, 9'd0);
    send_word(OpClear, 9'd0);
    send_word(OpAppend, 9'd0);
    send_word(3'd5, 9'd0);
    send_word(3'd6, 9'd1);
    send_word(3'd7, 9'h1FF);
    // zero capacity: tombstone reuse only
    set_mode(0, 0, 0);
    send_word(OpDelete, 9'd1);
    send_word(OpAppend, 9'd0);
    send_word(OpAppend, 9'd0);
    send_word(OpCompact, 9'd0);
  endtask

  // Ring: fill, overwrite, iterate, illegal ops, zero and shrunk capacity
  task automatic test_ring();
    set_mode(3, 1, 1);
    send_word(OpClear, 9'd0);
    for (int i = 0; i < 5; i++) send_word(OpAppend, 9'd0);
    for (int i = 0; i < 5; i++) send_word(OpNext, i[8:0]);
    send_word(OpDelete, 9'd1);
    send_word(OpCompact, 9'd0);
    set_mode(2, 1, 1);
    send_word(OpAppend, 9'd0);
    send_word(OpNext, 9'd0);
    set_mode(0, 1, 0);
    send_word(OpAppend, 9'd0);
    send_word(OpNext, 9'd0);
    send_word(OpNext, 9'd1);
    set_mode(5, 1, 0);
    send_word(OpClear, 9'd0);
    send_word(OpAppend, 9'd0);
    set_mode(1, 1, 0);
    send_word(OpAppend, 9'd0);
    send_word(OpAppend, 9'd0);
  endtask

  // Full table at the largest size
  task automatic test_fill();
    set_mode(256, 0, 1);
    send_word(OpClear, 9'd0);
    for (int i = 0; i < 258; i++) send_word(OpAppend, 9'd0);
    send_word(OpDelete, 9'd256);
    send_word(OpDelete, 9'd1);
    send_word(OpNext, 9'd255);
    send_word(OpAppend, 9'd0);
    set_mode(511, 1, 1);
    send_word(OpAppend, 9'd0);
    send_word(OpNext, 9'd0);
    send_word(OpNext, 9'd256);
  endtask

  // Mostly sensible traffic, some noise
  task automatic test_random(int cap, int ring, int fl, int n);
    int pick;
    logic [2:0] op;
    logic [8:0] rn;
    set_mode(cap, ring, fl);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 40) op = OpAppend;
      else if (pick < 65) op = OpDelete;
      else if (pick < 85) op = OpNext;
      else if (pick < 91) op = OpCompact;
      else if (pick < 94) op = OpClear;
      else op = 3'($urandom_range(7));
      if ($urandom_range(9) == 0) rn = 9'($urandom_range(511));
      else rn = 9'($urandom_range(used_n + 1));
      send_word(op, rn);
    end
  endtask

  initial begin
    used_n = 0;
    live_n = 0;
    flist_top = Slots;
    ring_old = 0;
    cap_reg = 256;
    ring_reg = 0;
    flist_reg = 1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    snd_idle = 36;
    rcv_idle = 86;
    test_directed();
    test_ring();
    test_random(8, 0, 1, 90);
    test_random(3, 1, 0, 80);
    test_random(256, 0, 0, 80);
    snd_idle = 86;
    rcv_idle = 36;
    test_random(1, 0, 1, 80);
    test_random(6, 1, 1, 80);
    test_random(5, 0, 0, 80);
    snd_idle = 0;
    rcv_idle = 0;
    test_fill();
    test_random(12, 0, 1, 90);
    test_random(0, 0, 1, 60);
    test_random(4, 1, 0, 80);
    test_random(300, 0, 1, 80);

    drain();
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
